>>> rtl/neighbor_mobility_score_unit_assert.svh
// Assertion macros used by the port checker of the neighbour mobility score unit.
// Each macro takes a label, a clock, an active-low reset, two expressions and a message.
`ifndef NEIGHBOR_MOBILITY_SCORE_UNIT_ASSERT_SVH
`define NEIGHBOR_MOBILITY_SCORE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NMS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/nms_pkg.sv
// Types and fixed constants of the neighbour mobility score unit.
// Used by the top level, its port checker and the testbench; depends on nothing else.
package nms_pkg;

	localparam int SPEED_W  = 16;
	localparam int ACCEL_W  = 16;
	localparam int DEGREE_W = 8;
	localparam int DIST_W   = 20;
	localparam int WEIGHT_W = 16;
	localparam int SCORE_W  = 32;
	localparam int SUM_W    = 40;
	localparam int NUM_W    = 40;
	localparam int PART_W   = NUM_W + WEIGHT_W;
	localparam int ACC_W    = PART_W + 2;
	localparam int BIT_W    = $clog2(NUM_W);
	localparam int MBIT_W   = $clog2(WEIGHT_W);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_VELOCITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DENSITY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ACCEL    = 2'd2;

	localparam logic [WEIGHT_W-1:0] WEIGHT_VELOCITY_RST = 16'd32768;
	localparam logic [WEIGHT_W-1:0] WEIGHT_DENSITY_RST  = 16'd19661;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ACCEL_RST    = 16'd13107;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_POST,
		ST_FIN,
		ST_MUL,
		ST_MADD,
		ST_SCORE
	} state_t;

	typedef enum logic [2:0] {
		OP_VEL,
		OP_ACC,
		OP_VCI,
		OP_DNAR,
		OP_RAV
	} op_t;

endpackage

>>> rtl/neighbor_mobility_score_unit.sv
// Neighbour mobility score unit: one neighbour per input beat, one score per neighbour list.
// Depends on nms_pkg; all divisions and weight multiplications run through one radix-2
// divider and one shift-add multiplier. A present neighbour at nonzero distance, taken while
// the neighbour count is below MAX_PEERS, needs two 40-step divisions and stalls the input
// until both are done; an absent neighbour or one at zero distance does not stall the input
// unless it closes the list. The closing beat of a list adds, for a nonzero degree, three
// divisions by the degree, each followed by a 16-step weight multiplication, before the
// score beat is offered. The divider produces one quotient bit per cycle. The input is taken
// again once the score sits in the output register, even while that beat is still stalled.
module neighbor_mobility_score_unit
	import nms_pkg::*;
#(
	parameter int MAX_PEERS = 255
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [WEIGHT_W-1:0]   cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [SPEED_W-1:0]    own_speed,
	input  logic signed [ACCEL_W-1:0] own_accel,
	input  logic [DEGREE_W-1:0]   own_degree,
	input  logic [SPEED_W-1:0]    peer_speed,
	input  logic signed [ACCEL_W-1:0] peer_accel,
	input  logic [DIST_W-1:0]     peer_distance,
	input  logic                  peer_present,
	input  logic                  is_last,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SCORE_W-1:0]    score,
	output logic                  score_saturated
);

	localparam int CNT_W = $clog2(MAX_PEERS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PEERS);

	state_t state_q, state_next;
	op_t    op_q;

	logic [WEIGHT_W-1:0] wv_q, wd_q, wa_q;
	logic [SUM_W-1:0]    vsum_q, asum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                clip_q;

	logic [NUM_W-1:0]    num_q;
	logic [DIST_W-1:0]   rem_q;
	logic [DIST_W-1:0]   div_q;
	logic [BIT_W-1:0]    bit_q;
	logic [ACCEL_W-1:0]  diff_q;
	logic [DEGREE_W-1:0] deg_q;
	logic                last_q;

	logic [WEIGHT_W-1:0] wsh_q;
	logic [MBIT_W-1:0]   mbit_q;
	logic [PART_W-1:0]   part_q;
	logic [ACC_W-1:0]    acc_q;

	logic                out_valid_q;
	logic [SCORE_W-1:0]  score_q;
	logic                sat_q;

	logic                accept;
	logic                out_load;
	logic                cnt_full;
	logic                launch;
	logic                div_last;
	logic                mul_last;

	logic [ACCEL_W:0]    accel_d;
	logic [ACCEL_W:0]    accel_mag;

	logic [DIST_W:0]     trial;
	logic [DIST_W:0]     trial_sub;
	logic                trial_ge;

	logic                term_clip;
	logic [SCORE_W-1:0]  term;
	logic [SUM_W-1:0]    sum_in;
	logic [SUM_W:0]      sum_add;
	logic                sum_clip;
	logic [SUM_W-1:0]    sum_new;

	logic                score_clip;
	logic [WEIGHT_W-1:0] weight_sel;

	// Handshake and decode of the incoming beat.
	assign accept   = in_valid & ~in_stall;
	assign cnt_full = (cnt_q >= CNT_MAX);
	assign launch   = peer_present & ~cnt_full & (peer_distance != '0);

	assign accel_d   = {own_accel[ACCEL_W-1], own_accel} - {peer_accel[ACCEL_W-1], peer_accel};
	assign accel_mag = accel_d[ACCEL_W] ? (~accel_d + 1'b1) : accel_d;

	// One restoring division step: the quotient bit shifts into the numerator register.
	assign trial     = {rem_q, num_q[NUM_W-1]};
	assign trial_sub = trial - {1'b0, div_q};
	assign trial_ge  = ~trial_sub[DIST_W];
	assign div_last  = (bit_q == BIT_W'(NUM_W - 1));
	assign mul_last  = (mbit_q == MBIT_W'(WEIGHT_W - 1));

	// Clipping of a finished per-neighbour term and its saturating accumulation.
	assign term_clip = (num_q[NUM_W-1:SCORE_W] != '0);
	assign term      = term_clip ? '1 : num_q[SCORE_W-1:0];
	assign sum_in    = (op_q == OP_VEL) ? vsum_q : asum_q;
	assign sum_add   = {1'b0, sum_in} + (SUM_W + 1)'(term);
	assign sum_clip  = sum_add[SUM_W];
	assign sum_new   = sum_clip ? '1 : sum_add[SUM_W-1:0];

	assign score_clip = (acc_q[ACC_W-1:SCORE_W+WEIGHT_W] != '0);

	always_comb begin
		case (op_q)
			OP_VCI:  weight_sel = wv_q;
			OP_DNAR: weight_sel = wd_q;
			OP_RAV:  weight_sel = wa_q;
			default: weight_sel = '0;
		endcase
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (launch)
						state_next = ST_DIV;
					else if (is_last)
						state_next = ST_FIN;
				end
			end
			ST_DIV: begin
				if (div_last)
					state_next = ST_POST;
			end
			ST_POST: begin
				case (op_q)
					OP_VEL:  state_next = ST_DIV;
					OP_ACC:  state_next = last_q ? ST_FIN : ST_IDLE;
					default: state_next = ST_MUL;
				endcase
			end
			ST_FIN: begin
				state_next = (deg_q == '0) ? ST_SCORE : ST_DIV;
			end
			ST_MUL: begin
				if (mul_last)
					state_next = ST_MADD;
			end
			ST_MADD: begin
				state_next = (op_q == OP_RAV) ? ST_SCORE : ST_DIV;
			end
			ST_SCORE: begin
				if (out_load)
					state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_load = (state_q == ST_SCORE) & (~out_valid_q | ~out_stall);
	end

	// Control state, list accumulators and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_VEL;
			bit_q       <= '0;
			mbit_q      <= '0;
			cnt_q       <= '0;
			clip_q      <= 1'b0;
			vsum_q      <= '0;
			asum_q      <= '0;
			out_valid_q <= 1'b0;
			wv_q        <= WEIGHT_VELOCITY_RST;
			wd_q        <= WEIGHT_DENSITY_RST;
			wa_q        <= WEIGHT_ACCEL_RST;
		end else begin
			state_q <= state_next;

			if (cfg_wr_en) begin
				case (cfg_index)
					REG_WEIGHT_VELOCITY: wv_q <= cfg_data;
					REG_WEIGHT_DENSITY:  wd_q <= cfg_data;
					REG_WEIGHT_ACCEL:    wa_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					bit_q <= '0;
					op_q  <= OP_VEL;
					if (accept && peer_present) begin
						if (cnt_full)
							clip_q <= 1'b1;
						else
							cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					bit_q <= bit_q + 1'b1;
				end
				ST_POST: begin
					bit_q  <= '0;
					mbit_q <= '0;
					if (op_q == OP_VEL || op_q == OP_ACC) begin
						if (term_clip || sum_clip)
							clip_q <= 1'b1;
						if (op_q == OP_VEL)
							vsum_q <= sum_new;
						else
							asum_q <= sum_new;
					end
					if (op_q == OP_VEL)
						op_q <= OP_ACC;
				end
				ST_FIN: begin
					bit_q <= '0;
					op_q  <= OP_VCI;
				end
				ST_MUL: begin
					mbit_q <= mbit_q + 1'b1;
				end
				ST_MADD: begin
					bit_q <= '0;
					case (op_q)
						OP_VCI:  op_q <= OP_DNAR;
						OP_DNAR: op_q <= OP_RAV;
						default: ;
					endcase
				end
				ST_SCORE: begin
					// The list state is cleared as the score is loaded into the output register.
					if (out_load) begin
						vsum_q <= '0;
						asum_q <= '0;
						cnt_q  <= '0;
						clip_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Divider, multiplier and output payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					num_q  <= {(2*SPEED_W)'(own_speed) * (2*SPEED_W)'(peer_speed), 8'd0};
					rem_q  <= '0;
					div_q  <= peer_distance;
					diff_q <= accel_mag[ACCEL_W-1:0];
					deg_q  <= own_degree;
					last_q <= is_last;
				end
			end
			ST_DIV: begin
				num_q <= {num_q[NUM_W-2:0], trial_ge};
				rem_q <= trial_ge ? trial_sub[DIST_W-1:0] : trial[DIST_W-1:0];
			end
			ST_POST: begin
				if (op_q == OP_VEL) begin
					num_q <= NUM_W'({diff_q, 16'd0});
					rem_q <= '0;
				end
				wsh_q  <= weight_sel;
				part_q <= '0;
			end
			ST_FIN: begin
				acc_q <= '0;
				num_q <= vsum_q;
				rem_q <= '0;
				div_q <= DIST_W'(deg_q);
			end
			ST_MUL: begin
				// Weight bits are taken most significant first.
				part_q <= {part_q[PART_W-2:0], 1'b0} + (wsh_q[WEIGHT_W-1] ? PART_W'(num_q) : '0);
				wsh_q  <= {wsh_q[WEIGHT_W-2:0], 1'b0};
			end
			ST_MADD: begin
				acc_q <= acc_q + ACC_W'(part_q);
				rem_q <= '0;
				if (op_q == OP_VCI)
					num_q <= NUM_W'({cnt_q, 16'd0});
				else
					num_q <= asum_q;
			end
			ST_SCORE: begin
				if (out_load) begin
					score_q <= score_clip ? '1 : acc_q[SCORE_W+WEIGHT_W-1:WEIGHT_W];
					sat_q   <= clip_q | score_clip;
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign score           = score_q;
	assign score_saturated = sat_q;

endmodule

>>> rtl/nms_checker.sv
// Port checker for the neighbour mobility score unit, bound to the top level.
// Depends on nms_pkg for widths and on the assertion macro header.
`include "neighbor_mobility_score_unit_assert.svh"

module nms_checker
	import nms_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [DIST_W-1:0]     peer_distance,
	input logic                  peer_present,
	input logic                  is_last,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [SCORE_W-1:0]    score,
	input logic                  score_saturated
);

	// A stalled score beat stays offered and unchanged.
	`NMS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(score) && $stable(score_saturated), "stalled score beat changed")

	// A beat that brings no division and does not close the list is absorbed at once.
	`NMS_ASSERT_NEXT(a_quick_beat, clk, arst_n, in_valid && !in_stall && !is_last && (!peer_present || peer_distance == '0), !in_stall, "simple beat stalled the input")

	// A closing beat always stalls the input while its score is produced.
	`NMS_ASSERT_NEXT(a_last_busy, clk, arst_n, in_valid && !in_stall && is_last, in_stall, "closing beat did not start the score")

	// A score appears only at the end of processing, never out of an idle input.
	`NMS_ASSERT_SAME(a_score_origin, clk, arst_n, $rose(out_valid), $past(in_stall), "score beat without a closing beat")

endmodule

bind neighbor_mobility_score_unit nms_checker u_nms_checker (.*);

>>> test/neighbor_mobility_score_unit_test.sv
// Self-checking testbench of neighbor_mobility_score_unit: neighbour lists in, scores out.
// Depends on nms_pkg and the unit itself; expected scores come from a fixed-point predictor
// kept in step with every accepted input beat, or for typed directed rows from their table.
module neighbor_mobility_score_unit_test;
	import nms_pkg::*;

	localparam int MAX_PEERS = 255;
	localparam int LIMIT_CYCLES = 1_500_000;
	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_CYCLES = 3000;
	localparam int PHASE_ITEMS = 120;
	localparam int NUM_PHASES = 8;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam longint unsigned TERM_MAX = 64'hFFFF_FFFF;
	localparam longint unsigned SUM_MAX = 64'hFF_FFFF_FFFF;

	typedef struct packed {
		logic [SPEED_W-1:0]        own_speed;
		logic signed [ACCEL_W-1:0] own_accel;
		logic [DEGREE_W-1:0]       own_degree;
		logic [SPEED_W-1:0]        peer_speed;
		logic signed [ACCEL_W-1:0] peer_accel;
		logic [DIST_W-1:0]         peer_distance;
		logic                      peer_present;
		logic                      is_last;
	} nbr_item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               saturated;
	} score_beat_t;

	typedef struct packed {
		nbr_item_t   item;
		logic [8:0]  copies;
		bit          typed;
		score_beat_t want;
	} dir_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WEIGHT_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [SPEED_W-1:0] own_speed = '0;
	logic signed [ACCEL_W-1:0] own_accel = '0;
	logic [DEGREE_W-1:0] own_degree = '0;
	logic [SPEED_W-1:0] peer_speed = '0;
	logic signed [ACCEL_W-1:0] peer_accel = '0;
	logic [DIST_W-1:0] peer_distance = '0;
	logic peer_present = 1'b0;
	logic is_last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [SCORE_W-1:0] score;
	logic score_saturated;

	// Predictor state: weights as last written, the running list sums, peer count and clip flag.
	longint unsigned w_velocity = WEIGHT_VELOCITY_RST;
	longint unsigned w_density = WEIGHT_DENSITY_RST;
	longint unsigned w_accel = WEIGHT_ACCEL_RST;
	longint unsigned model_vsum = 0;
	longint unsigned model_asum = 0;
	int model_peers = 0;
	bit model_clip = 1'b0;

	score_beat_t pending_scores [$];
	dir_row_t dir_rows [$];
	int fail_count = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit hold_start = 1'b0;
	int hold_left = 0;

	neighbor_mobility_score_unit #(.MAX_PEERS(MAX_PEERS)) dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned saturate(input longint unsigned v,
			input longint unsigned top);
		if (v > top) begin
			model_clip = 1'b1;
			return top;
		end
		return v;
	endfunction

	// Folds one accepted beat into the list state; returns 1 with the score on a closing beat.
	function automatic bit predict_score(input nbr_item_t it, output score_beat_t res);
		longint unsigned span, vt, at, diff, vci, rav, dnar, deg;
		int d;
		res = '0;
		span = it.peer_distance;
		if (it.peer_present) begin
			if (model_peers >= MAX_PEERS) begin
				model_clip = 1'b1;
			end else begin
				model_peers++;
				if (span != 0) begin
					d = int'(it.own_accel) - int'(it.peer_accel);
					diff = longint'((d < 0) ? -d : d);
					vt = (({48'd0, it.own_speed} * {48'd0, it.peer_speed}) << 8) / span;
					at = (diff << 16) / span;
					model_vsum = saturate(model_vsum + saturate(vt, TERM_MAX), SUM_MAX);
					model_asum = saturate(model_asum + saturate(at, TERM_MAX), SUM_MAX);
				end
			end
		end
		if (!it.is_last)
			return 1'b0;
		deg = it.own_degree;
		if (deg != 0) begin
			vci = model_vsum / deg;
			rav = model_asum / deg;
			dnar = (longint'(model_peers) << 16) / deg;
			res.score = SCORE_W'(saturate((w_velocity * vci + w_density * dnar
				+ w_accel * rav) >> 16, TERM_MAX));
		end
		res.saturated = model_clip;
		model_vsum = 0;
		model_asum = 0;
		model_peers = 0;
		model_clip = 1'b0;
		return 1'b1;
	endfunction

	function automatic dir_row_t mk_row(input logic [15:0] os, input logic [15:0] oa,
			input int deg, input logic [15:0] ps, input logic [15:0] pa,
			input logic [19:0] pdist, input bit pres, input bit last, input int copies,
			input bit typed, input longint unsigned want_score, input bit want_sat);
		dir_row_t r;
		r.item = '{os, oa, DEGREE_W'(deg), ps, pa, pdist, pres, last};
		r.copies = 9'(copies);
		r.typed = typed;
		r.want = '{SCORE_W'(want_score), want_sat};
		return r;
	endfunction

	function automatic logic [SPEED_W-1:0] rand_speed();
		case ($urandom_range(0, 3))
			0: return SPEED_W'(16'hFFFF - $urandom_range(0, 255));
			1: return SPEED_W'($urandom_range(0, 255));
			default: return SPEED_W'($urandom);
		endcase
	endfunction

	function automatic logic [ACCEL_W-1:0] rand_accel();
		case ($urandom_range(0, 3))
			0: return ACCEL_W'(16'h7FFF - $urandom_range(0, 255));
			1: return ACCEL_W'(16'h8000 + $urandom_range(0, 255));
			default: return ACCEL_W'($urandom);
		endcase
	endfunction

	task automatic send_item(input nbr_item_t it, input bit typed, input score_beat_t want);
		score_beat_t res;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		own_speed <= it.own_speed;
		own_accel <= it.own_accel;
		own_degree <= it.own_degree;
		peer_speed <= it.peer_speed;
		peer_accel <= it.peer_accel;
		peer_distance <= it.peer_distance;
		peer_present <= it.peer_present;
		is_last <= it.is_last;
		do begin
			@(posedge clk);
		end while (in_stall);
		if (it.peer_present || it.is_last)
			items_sent++;
		if (predict_score(it, res))
			pending_scores = {pending_scores, (typed ? want : res)};
	endtask

	// Mostly one node's list with steady own fields; now and then a list whose own fields
	// wander from beat to beat and whose neighbours come and go.
	task automatic send_random_list();
		nbr_item_t it;
		int len;
		int beats;
		bit noisy;
		noisy = ($urandom_range(0, 9) == 0);
		len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
		beats = (len == 0) ? 1 : len;
		it.own_speed = rand_speed();
		it.own_accel = rand_accel();
		case ($urandom_range(0, 9))
			0: it.own_degree = '0;
			1, 2, 3, 4, 5, 6: it.own_degree = DEGREE_W'($urandom_range(1, 8));
			default: it.own_degree = DEGREE_W'($urandom_range(9, 255));
		endcase
		for (int i = 0; i < beats; i++) begin
			if (noisy) begin
				it.own_speed = rand_speed();
				it.own_accel = rand_accel();
				it.own_degree = DEGREE_W'($urandom);
			end
			it.peer_speed = rand_speed();
			it.peer_accel = rand_accel();
			case ($urandom_range(0, 7))
				0: it.peer_distance = '0;
				1: it.peer_distance = DIST_W'($urandom_range(1, 15));
				2: it.peer_distance = DIST_W'(20'hFFFFF - $urandom_range(0, 1023));
				3: it.peer_distance = DIST_W'($urandom_range(16, 4095));
				default: it.peer_distance = DIST_W'($urandom);
			endcase
			it.peer_present = (len != 0) && (!noisy || $urandom_range(0, 2) != 0);
			it.is_last = (i == beats - 1);
			send_item(it, 1'b0, '0);
		end
	endtask

	// Lets every pending score drain and the divider finish before anything is reconfigured.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_weights(input logic [WEIGHT_W-1:0] wv, input logic [WEIGHT_W-1:0] wd,
			input logic [WEIGHT_W-1:0] wa);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_WEIGHT_VELOCITY;
		cfg_data <= wv;
		@(posedge clk);
		cfg_index <= REG_WEIGHT_DENSITY;
		cfg_data <= wd;
		@(posedge clk);
		cfg_index <= REG_WEIGHT_ACCEL;
		cfg_data <= wa;
		@(posedge clk);
		// A write to the spare index must leave all three weights alone.
		cfg_index <= REG_UNUSED;
		cfg_data <= WEIGHT_W'($urandom);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		w_velocity = wv;
		w_density = wd;
		w_accel = wa;
	endtask

	initial begin
		int phase_end;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// os, oa, degree, ps, pa, distance, present, last, copies, typed, score, saturated
		dir_rows = '{
			mk_row('h0000, 'h0000,   0, 'h0000, 'h0000, 'h00000, 0, 1,   1, 1,     0, 0),
			mk_row('hFFFF, 'h7FFF, 255, 'hFFFF, 'h8000, 'hFFFFF, 0, 1,   1, 1,     0, 0),
			mk_row('hFFFF, 'h8000,   1, 'hFFFF, 'h7FFF, 'h00000, 1, 1,   1, 1, 19661, 0),
			mk_row('h1234, 'h0100,   0, 'h4321, 'hFF00, 'h00000, 1, 1,   1, 1,     0, 0),
			mk_row('hFFFF, 'h7FFF,   1, 'hFFFF, 'h8000, 'h00001, 1, 0,   1, 0,     0, 0),
			mk_row('h0000, 'h0000,   1, 'h0000, 'h0000, 'h00000, 0, 1,   1, 0,     0, 0),
			mk_row('hFFFF, 'h7FFF,   0, 'hFFFF, 'h8000, 'h00001, 1, 1,   1, 1,     0, 1),
			mk_row('h0000, 'h8000,   2, 'h0000, 'h7FFF, 'h00001, 1, 0,   1, 0,     0, 0),
			mk_row('hFFFF, 'h0000,   2, 'hFFFF, 'h0000, 'hFFFFF, 1, 0,   1, 0,     0, 0),
			mk_row('h0001, 'h0001,   2, 'h0001, 'h0000, 'h00001, 1, 0,   1, 0,     0, 0),
			mk_row('hAAAA, 'h5555,   2, 'h5555, 'hAAAA, 'h12345, 0, 0,   1, 0,     0, 0),
			mk_row('h0C80, 'hFE80,   3, 'h0A00, 'h0140, 'h00010, 1, 1,   1, 0,     0, 0),
			mk_row('h0000, 'h0000,   0, 'h0000, 'h0000, 'h00000, 1, 0, 260, 0,     0, 0),
			mk_row('h0000, 'h0000, 255, 'h0000, 'h0000, 'h00000, 0, 1,   1, 1, 19661, 1),
			mk_row('h0100, 'h0000, 255, 'h0100, 'h0000, 'h00100, 1, 1,   1, 0,     0, 0),
			mk_row('hFFFF, 'h0000, 128, 'h0001, 'hFFFF, 'hFFFFF, 1, 1,   1, 0,     0, 0)
		};
		foreach (dir_rows[r]) begin
			for (int c = 0; c < dir_rows[r].copies; c++)
				send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			case (p)
				0: load_weights('1, '1, '1);
				1: load_weights('0, '0, '0);
				default: load_weights(WEIGHT_W'($urandom), WEIGHT_W'($urandom),
					WEIGHT_W'($urandom));
			endcase
			case (p % 4)
				0: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
				1: begin
					tx_idle_pct = 84;
					rx_idle_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_idle_pct = 84;
				end
				default: begin
					tx_idle_pct = 24;
					rx_idle_pct = 24;
				end
			endcase
			// The receiver holds off while beats keep coming, so the unit backs up.
			if (p == 4)
				hold_start = 1'b1;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end)
				send_random_list();
		end

		settle();
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_start) begin
				hold_left = HOLD_CYCLES;
				hold_start = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		score_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_scores.size() == 0) begin
				$error("score beat with none expected: score %0d, score_saturated %0d",
					score, score_saturated);
				fail_count++;
			end else begin
				want = pending_scores.pop_front();
				if (score !== want.score) begin
					$error("score: expected %0d, actual %0d", want.score, score);
					fail_count++;
				end
				if (score_saturated !== want.saturated) begin
					$error("score_saturated: expected %0d, actual %0d", want.saturated,
						score_saturated);
					fail_count++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
